FILE: design/matrix3_inverse_top_defines.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level; no dependencies.
`ifndef MATRIX3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3_INVERSE_TOP_DEFINES_SVH
`define M3I_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/m3i_pkg.sv
// Package of the 3x3 matrix inverse block: widths, payload types.
// No dependencies.
package m3i_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ElemW = 32;
  localparam int unsigned CofW = 65;
  localparam int unsigned DetW = 98;
  localparam int unsigned NumW = CofW + 2 * FracBits;
  localparam int unsigned QW = NumW;
  localparam int unsigned Stages = NumW;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t a11; elem_t a12; elem_t a13;
    elem_t a21; elem_t a22; elem_t a23;
    elem_t a31; elem_t a32; elem_t a33;
  } mat_in_t;

  typedef struct packed {
    elem_t r11; elem_t r12; elem_t r13;
    elem_t r21; elem_t r22; elem_t r23;
    elem_t r31; elem_t r32; elem_t r33;
    logic singular;
    logic saturated;
  } mat_out_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [NumW-1:0] num;
    logic [QW-1:0] quo;
  } div_lane_t;
endpackage

FILE: design/m3i_if.sv
// Valid/ready channel interfaces of the matrix inverse block.
// Depends on m3i_pkg.
interface m3i_in_if;
  logic valid;
  logic ready;
  m3i_pkg::mat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m3i_out_if;
  logic valid;
  logic ready;
  m3i_pkg::mat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/matrix3_inverse_top.sv
// Top level of the 3x3 fixed-point matrix inverse.
// Depends on m3i_pkg, m3i_if, m3i_front, m3i_divider and the defines header.
// Usage: one request on in_if carries nine signed Q16.16 elements; one
// result on out_if carries the inverse, a singular flag and a saturated flag.
// Both channels use valid/ready; a request is taken when both are high.
// The pipeline has three stages of cofactors and determinant, one
// input stage and 97 quotient-bit stages of the shared-divisor divider,
// and one sign and saturation stage.
// Throughput is one matrix per cycle while the receiver does not stall; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline holds, and
// ready follows the output side so a stalled result is never lost.
// Reset clears all valid bits; the data path holds no state needing reset.
`include "matrix3_inverse_top_defines.svh"
module matrix3_inverse_top (
  input logic clk_i,
  input logic rst_ni,
  m3i_in_if.sink in_if,
  m3i_out_if.source out_if
);
  logic en;
  logic f_valid;
  logic signed [m3i_pkg::CofW-1:0] adj [9];
  logic signed [m3i_pkg::DetW-1:0] det;

  assign en = out_if.ready || !out_if.valid;
  assign in_if.ready = en;

  m3i_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid && en), .mat_i(in_if.data),
    .valid_o(f_valid), .adj_o(adj), .det_o(det));

  m3i_divider u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .adj_i(adj), .det_i(det),
    .valid_o(out_if.valid), .res_o(out_if.data));

  `M3I_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `M3I_ASSERT_IMPL(a_sing, clk_i, rst_ni, out_if.valid && out_if.data.singular,
    !out_if.data.saturated && out_if.data.r11 == 0)
  `M3I_ASSERT_IMPL(a_ready, clk_i, rst_ni, !out_if.valid, in_if.ready)
endmodule

FILE: design/m3i_front.sv
// Front stages: cofactors, partial determinant products, determinant sum.
// Depends on m3i_pkg. Three register stages, advancing on en_i.
module m3i_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  m3i_pkg::mat_in_t mat_i,
  output logic valid_o,
  output logic signed [m3i_pkg::CofW-1:0] adj_o [9],
  output logic signed [m3i_pkg::DetW-1:0] det_o
);
  localparam int unsigned PW = 2 * m3i_pkg::ElemW;
  localparam int unsigned LW = PW + 1;
  logic signed [PW-1:0] p_q [18];
  logic signed [m3i_pkg::ElemW-1:0] c1_q [3];
  logic signed [m3i_pkg::CofW-1:0] adj_q [9];
  logic signed [m3i_pkg::CofW-1:0] adj2_q [9];
  logic signed [LW-1:0] lo_q [3];
  logic signed [LW-1:0] hi_q [3];
  logic signed [m3i_pkg::DetW-1:0] det_q;
  logic [2:0] v_q;
  logic signed [m3i_pkg::ElemW-1:0] x [9];
  logic signed [m3i_pkg::CofW-1:0] adj_d [9];

  assign x = '{mat_i.a11, mat_i.a12, mat_i.a13, mat_i.a21, mat_i.a22,
               mat_i.a23, mat_i.a31, mat_i.a32, mat_i.a33};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      adj_d[i] = m3i_pkg::CofW'(p_q[2*i]) - m3i_pkg::CofW'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= x[4] * x[8];  p_q[1] <= x[7] * x[5];
      p_q[2] <= x[7] * x[2];  p_q[3] <= x[1] * x[8];
      p_q[4] <= x[1] * x[5];  p_q[5] <= x[4] * x[2];
      p_q[6] <= x[6] * x[5];  p_q[7] <= x[3] * x[8];
      p_q[8] <= x[0] * x[8];  p_q[9] <= x[6] * x[2];
      p_q[10] <= x[3] * x[2]; p_q[11] <= x[0] * x[5];
      p_q[12] <= x[3] * x[7]; p_q[13] <= x[6] * x[4];
      p_q[14] <= x[6] * x[1]; p_q[15] <= x[0] * x[7];
      p_q[16] <= x[0] * x[4]; p_q[17] <= x[3] * x[1];
      c1_q <= '{x[0], x[3], x[6]};
      adj_q <= adj_d;
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= LW'($signed({1'b0, adj_d[i][m3i_pkg::ElemW-1:0]})) * LW'(c1_q[i]);
        hi_q[i] <= LW'($signed(adj_d[i][m3i_pkg::CofW-1:m3i_pkg::ElemW])) * LW'(c1_q[i]);
      end
      adj2_q <= adj_q;
      det_q <= (m3i_pkg::DetW'(hi_q[0]) <<< m3i_pkg::ElemW) + m3i_pkg::DetW'(lo_q[0])
             + (m3i_pkg::DetW'(hi_q[1]) <<< m3i_pkg::ElemW) + m3i_pkg::DetW'(lo_q[1])
             + (m3i_pkg::DetW'(hi_q[2]) <<< m3i_pkg::ElemW) + m3i_pkg::DetW'(lo_q[2]);
    end
  end

  assign valid_o = v_q[2];
  assign adj_o = adj2_q;
  assign det_o = det_q;
endmodule

FILE: design/m3i_divider.sv
// Pipelined restoring divider for nine quotients sharing one divisor,
// one quotient bit per stage, followed by sign and saturation. Depends on m3i_pkg.
module m3i_divider (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [m3i_pkg::CofW-1:0] adj_i [9],
  input  logic signed [m3i_pkg::DetW-1:0] det_i,
  output logic valid_o,
  output m3i_pkg::mat_out_t res_o
);
  localparam int unsigned N = m3i_pkg::NumW;
  localparam int unsigned DW = m3i_pkg::DetW;
  localparam int unsigned RW = DW + 1;
  m3i_pkg::div_lane_t lane_q [m3i_pkg::Stages+1][9];
  logic [m3i_pkg::Stages:0][8:0] neg_q;
  logic [m3i_pkg::Stages:0] v_q;
  logic [m3i_pkg::Stages:0] sing_q;
  logic [DW-1:0] dmag_q [m3i_pkg::Stages+1];
  logic [DW-1:0] dmag_d;
  m3i_pkg::mat_out_t res_q;
  logic v_out_q;

  assign dmag_d = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_q <= {v_q[m3i_pkg::Stages-1:0], valid_i};
      v_out_q <= v_q[m3i_pkg::Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        lane_q[0][i].rem <= '0;
        lane_q[0][i].quo <= '0;
        lane_q[0][i].num <= {(adj_i[i][m3i_pkg::CofW-1] ?
          m3i_pkg::CofW'(-adj_i[i]) : m3i_pkg::CofW'(adj_i[i])),
          {(2*m3i_pkg::FracBits){1'b0}}};
        neg_q[0][i] <= adj_i[i][m3i_pkg::CofW-1] ^ det_i[DW-1];
      end
      dmag_q[0] <= dmag_d;
      sing_q[0] <= (det_i == '0);
      for (int s = 0; s < m3i_pkg::Stages; s++) begin
        for (int i = 0; i < 9; i++) begin
          logic [RW-1:0] r;
          logic [RW:0] diff;
          r = {1'b0, lane_q[s][i].rem, lane_q[s][i].num[N-1]};
          diff = {1'b0, r} - {2'b0, dmag_q[s]};
          lane_q[s+1][i].num <= {lane_q[s][i].num[N-2:0], 1'b0};
          lane_q[s+1][i].rem <= N'(diff[RW] ? r : diff[RW-1:0]);
          lane_q[s+1][i].quo <= {lane_q[s][i].quo[N-2:0], ~diff[RW]};
        end
        neg_q[s+1] <= neg_q[s];
        dmag_q[s+1] <= dmag_q[s];
        sing_q[s+1] <= sing_q[s];
      end
      begin
        logic [31:0] r [9];
        logic sat;
        logic [N-1:0] q;
        sat = 1'b0;
        for (int i = 0; i < 9; i++) begin
          q = lane_q[m3i_pkg::Stages][i].quo;
          if (sing_q[m3i_pkg::Stages]) begin
            r[i] = '0;
          end else if (neg_q[m3i_pkg::Stages][i]) begin
            if (q > N'(32'h8000_0000)) begin
              r[i] = 32'h8000_0000; sat = 1'b1;
            end else begin
              r[i] = 32'(-q);
            end
          end else begin
            if (q > N'(32'h7fff_ffff)) begin
              r[i] = 32'h7fff_ffff; sat = 1'b1;
            end else begin
              r[i] = q[31:0];
            end
          end
        end
        res_q <= {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8],
                  sing_q[m3i_pkg::Stages], sat};
      end
    end
  end

  assign valid_o = v_out_q;
  assign res_o = res_q;
endmodule
